// File: hw/rtl/ilir_pkg.sv
// Package for the indexed list block: sizes, command and status codes,
// cell control types. No dependencies.

package ilir_pkg;

   // Number of cells in the list.
   localparam int DEPTH     = 32;
   localparam int DATA_W    = 32;
   localparam int CMD_W     = 3;
   localparam int INDEX_W   = 6;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 6;
   // Internal count must hold DEPTH itself.
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W     = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND = 3'd0,
      CMD_INSERT = 3'd1,
      CMD_REMOVE = 3'd2,
      CMD_CLEAR  = 3'd3,
      CMD_DUMP   = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // What every cell does in one cycle.
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_op_type;

   // Control word broadcast to the whole row of cells.
   typedef struct packed {
      cell_op_type              op;
      logic [CNT_W-1:0]         pos;
      logic [CNT_W-1:0]         cnt;
      logic signed [DATA_W-1:0] value;
   } cell_ctl_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_DUMP = 1'b1
   } state_type;

endpackage

// File: hw/rtl/indexed_list_insert_remove.sv
// A command's result word is registered and appears in the cycle after acceptance; the
// first word of a non-empty dump goes via the dump state, then the output register.
// Throughput: one command per cycle while the output is not stalled, except dump, which
// gives one word per element (one word when empty); the row of cells rotates by one per
// word sent, so a dump holds the input until its last word is sent. Reset clears the
// count, the state and the output valid flag; cell contents stay undefined until written.
// Top level: command decode, dump sequencer, output register and the cell row.

module indexed_list_insert_remove
   import ilir_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // req_tdata: command[2:0], index[8:3], value[40:9], zeros[47:41]
   input  logic [47:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rsp_tdata: element[31:0], count[37:32], zeros[39:38]
   output logic [39:0] rsp_tdata,
   // rsp_tuser: status[1:0]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready
);

   // Input field unpacking.
   cmd_type                  req_cmd;
   logic [INDEX_W-1:0]       req_index;
   logic signed [DATA_W-1:0] req_value;

   assign req_cmd   = cmd_type'(req_tdata[2:0]);
   assign req_index = req_tdata[8:3];
   assign req_value = req_tdata[40:9];

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         dump_idx_ff, dump_idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_element_ff, rsp_element_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                     rsp_last_ff, rsp_last_in;

   cell_ctl_type             ctl;
   logic signed [DATA_W-1:0] cell_q [DEPTH];

   logic                     out_free;
   logic                     accept;
   logic                     dump_step;
   logic                     dump_end;
   logic [CMP_W-1:0]         idx_cmp;
   logic [CMP_W-1:0]         cnt_cmp;
   logic                     full;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign accept    = req_tvalid && req_tready;
   assign dump_step = (state_ff == S_DUMP) && out_free;
   assign dump_end  = (dump_idx_ff + CNT_W'(1)) == count_ff;
   assign idx_cmp   = CMP_W'(req_index);
   assign cnt_cmp   = CMP_W'(count_ff);
   assign full      = count_ff >= CNT_W'(DEPTH);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_cmd == CMD_DUMP && count_ff != '0) begin
               state_in = S_DUMP;
            end
         end
         S_DUMP: begin
            if (dump_step && dump_end) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Handshake, cell control, count and output register.
   always_comb begin
      req_tready     = (state_ff == S_IDLE) && out_free;
      ctl.op         = CELL_HOLD;
      ctl.pos        = count_ff;
      ctl.cnt        = count_ff;
      ctl.value      = req_value;
      count_in       = count_ff;
      dump_idx_in    = dump_idx_ff;
      rsp_valid_in   = out_free ? 1'b0 : rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_last_in    = rsp_last_ff;

      if (accept) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = STAT_OK;
         rsp_element_in = '0;
         rsp_last_in    = 1'b1;
         unique case (req_cmd)
            CMD_APPEND: begin
               if (full) begin
                  rsp_status_in = STAT_FULL;
               end else begin
                  ctl.op   = CELL_INSERT;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_INSERT: begin
               if (idx_cmp > cnt_cmp) begin
                  rsp_status_in = STAT_RANGE;
               end else if (full) begin
                  rsp_status_in = STAT_FULL;
               end else begin
                  ctl.op   = CELL_INSERT;
                  ctl.pos  = CNT_W'(idx_cmp);
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_REMOVE: begin
               if (idx_cmp >= cnt_cmp) begin
                  rsp_status_in = STAT_RANGE;
               end else begin
                  ctl.op   = CELL_REMOVE;
                  ctl.pos  = CNT_W'(idx_cmp);
                  count_in = count_ff - CNT_W'(1);
               end
            end
            CMD_CLEAR: begin
               count_in = '0;
            end
            CMD_DUMP: begin
               // A non-empty dump is sent by the sequencer instead.
               dump_idx_in = '0;
               if (count_ff != '0) begin
                  rsp_valid_in = 1'b0;
               end
            end
            default: begin
               rsp_status_in = STAT_OK;
            end
         endcase
         rsp_count_in = COUNT_W'(count_in);
      end else if (dump_step) begin
         // Emit the head cell and rotate the row by one.
         ctl.op         = CELL_ROTATE;
         dump_idx_in    = dump_idx_ff + CNT_W'(1);
         rsp_valid_in   = 1'b1;
         rsp_status_in  = STAT_OK;
         rsp_element_in = cell_q[0];
         rsp_count_in   = COUNT_W'(count_ff);
         rsp_last_in    = dump_end;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload registers.
   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_element_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Row of cells, each wired to its neighbors.
   for (genvar j = 0; j < DEPTH; j++) begin : g_cell
      logic signed [DATA_W-1:0] low_val;
      logic signed [DATA_W-1:0] high_val;

      if (j == 0) begin : g_low_edge
         assign low_val = '0;
      end else begin : g_low_link
         assign low_val = cell_q[j-1];
      end

      if (j == DEPTH - 1) begin : g_high_edge
         assign high_val = '0;
      end else begin : g_high_link
         assign high_val = cell_q[j+1];
      end

      ilir_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .cell_idx (IDX_W'(j)),
         .low_val  (low_val),
         .high_val (high_val),
         .head_val (cell_q[0]),
         .cell_val (cell_q[j])
      );
   end

`ifndef NO_ASSERTIONS
   // The count never passes the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count above depth");

   // While dumping, the position stays below the count and no command is taken.
   a_dump_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |-> (dump_idx_ff < count_ff && !req_tready))
      else $error("dump position out of range or input open");

   // An error status is always the only word of its command.
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STAT_OK) |-> rsp_tlast)
      else $error("error status on a non-final word");

   // The count does not change while a dump is in progress.
   a_dump_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |=> $stable(count_ff))
      else $error("count changed during dump");
`endif

endmodule

// File: hw/rtl/ilir_cell.sv
// One cell of the list: holds one element and shifts with its neighbors.
// Depends on ilir_pkg.

module ilir_cell
   import ilir_pkg::*;
(
   input  logic                     clock,
   input  cell_ctl_type             ctl,
   input  logic [IDX_W-1:0]         cell_idx,
   input  logic signed [DATA_W-1:0] low_val,
   input  logic signed [DATA_W-1:0] high_val,
   input  logic signed [DATA_W-1:0] head_val,
   output logic signed [DATA_W-1:0] cell_val
);

   logic signed [DATA_W-1:0] cell_ff;
   logic signed [DATA_W-1:0] cell_in;
   logic [CNT_W-1:0]         pos_j;
   logic [CNT_W-1:0]         pos_j1;

   assign pos_j  = CNT_W'(cell_idx);
   assign pos_j1 = pos_j + CNT_W'(1);

   // Pick the next element from the broadcast control word.
   always_comb begin
      cell_in = cell_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (pos_j == ctl.pos) begin
               cell_in = ctl.value;
            end else if (pos_j > ctl.pos && pos_j <= ctl.cnt) begin
               cell_in = low_val;
            end
         end
         CELL_REMOVE: begin
            if (pos_j >= ctl.pos && pos_j1 < ctl.cnt) begin
               cell_in = high_val;
            end
         end
         CELL_ROTATE: begin
            // The head wraps around to the last occupied cell.
            if (pos_j1 < ctl.cnt) begin
               cell_in = high_val;
            end else if (pos_j1 == ctl.cnt) begin
               cell_in = head_val;
            end
         end
         default: begin
            cell_in = cell_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign cell_val = cell_ff;

endmodule

// File: sim/indexed_list_insert_remove_tb.sv
`timescale 1ns / 1ps
// Testbench for indexed_list_insert_remove: drives command words, predicts every result word
// from its own copy of the list, and checks the result stream field by field.
// Depends on ilir_pkg and the indexed_list_insert_remove top level only.

module indexed_list_insert_remove_tb;
   import ilir_pkg::*;

   // Command codes with no function; the block answers them as a no-op.
   localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   localparam int IDLE_PCT    = 15;
   localparam int CYCLE_LIMIT = 300000;

   // One result word as the list reports it.
   typedef struct packed {
      status_type               status;
      logic signed [DATA_W-1:0] element;
      logic [COUNT_W-1:0]       count;
      logic                     last;
   } list_word_type;

   logic        clock;
   logic        reset;
   logic [47:0] req_tdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;

   // Predicted list contents and the result words still owed by the block.
   logic signed [DATA_W-1:0] list_cells [DEPTH];
   int                       list_count;
   list_word_type            pending_words [$];

   int  error_count;
   int  cycle_count;
   int  hold_left;
   bit  quiet;

   indexed_list_insert_remove u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Place an element at a position, shifting the later ones up.
   function automatic status_type store_element(int pos, logic signed [DATA_W-1:0] val);
      if (list_count >= DEPTH) return STAT_FULL;
      for (int j = list_count; j > pos; j--) list_cells[j] = list_cells[j - 1];
      list_cells[pos] = val;
      list_count++;
      return STAT_OK;
   endfunction

   // Update the predicted list for one accepted command and queue its result words.
   function automatic void apply_command(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
                                         logic signed [DATA_W-1:0] val);
      status_type    status;
      list_word_type w;
      status = STAT_OK;
      case (cmd)
         CMD_APPEND: status = store_element(list_count, val);
         CMD_INSERT: begin
            if (int'(idx) > list_count) status = STAT_RANGE;
            else status = store_element(int'(idx), val);
         end
         CMD_REMOVE: begin
            if (int'(idx) >= list_count) begin
               status = STAT_RANGE;
            end else begin
               for (int j = int'(idx); j + 1 < list_count; j++) list_cells[j] = list_cells[j + 1];
               list_count--;
            end
         end
         CMD_CLEAR: list_count = 0;
         CMD_DUMP: begin
            if (list_count > 0) begin
               for (int j = 0; j < list_count; j++) begin
                  w.status  = STAT_OK;
                  w.element = list_cells[j];
                  w.count   = COUNT_W'(list_count);
                  w.last    = (j + 1 == list_count);
                  pending_words.push_back(w);
               end
               return;
            end
         end
         default: ;
      endcase
      w.status  = status;
      w.element = '0;
      w.count   = COUNT_W'(list_count);
      w.last    = 1'b1;
      pending_words.push_back(w);
   endfunction

   // Offer one command word, with random idle cycles ahead of it, and wait for acceptance.
   // Valid is left high; only idle cycles of the next call or the end of the run lower it.
   task automatic send_word(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
                            logic signed [DATA_W-1:0] val);
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= {7'b0, val, idx, cmd};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      apply_command(cmd, idx, val);
      @(negedge clock);
   endtask

   // Mostly random values, with the extremes mixed in.
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 19))
         0: return VAL_MIN;
         1: return VAL_MAX;
         2: return '0;
         3: return -1;
         default: return $urandom;
      endcase
   endfunction

   // Random commands, mostly well formed against the current predicted count.
   task automatic random_items(int n);
      int                 r;
      logic [CMD_W-1:0]   cmd;
      logic [INDEX_W-1:0] idx;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 25)      cmd = CMD_APPEND;
         else if (r < 47) cmd = CMD_INSERT;
         else if (r < 79) cmd = CMD_REMOVE;
         else if (r < 82) cmd = CMD_CLEAR;
         else if (r < 97) cmd = CMD_DUMP;
         else             cmd = CMD_W'($urandom_range(5, 7));
         if ($urandom_range(0, 99) < 10) begin
            idx = INDEX_W'($urandom_range(0, 63));
         end else if (cmd == CMD_REMOVE && list_count > 0) begin
            idx = INDEX_W'($urandom_range(0, list_count - 1));
         end else begin
            idx = INDEX_W'($urandom_range(0, list_count));
         end
         send_word(cmd, idx, pick_value());
      end
   endtask

   // Empty list behavior and the unused command codes.
   task automatic test_empty_list();
      send_word(CMD_DUMP, 0, 0);
      send_word(CMD_REMOVE, 0, 0);
      send_word(CMD_INSERT, 1, 32'sd5);
      send_word(CMD_SPARE5, 63, -1);
      send_word(CMD_SPARE6, 0, 0);
      send_word(CMD_SPARE7, 21, VAL_MAX);
      send_word(CMD_INSERT, 0, VAL_MIN);
      send_word(CMD_CLEAR, 0, 0);
      send_word(CMD_DUMP, 0, 0);
   endtask

   // Extreme values and indexes at the edges of the list.
   task automatic test_edges();
      send_word(CMD_APPEND, 63, VAL_MIN);
      send_word(CMD_APPEND, 0, VAL_MAX);
      send_word(CMD_INSERT, 0, -1);
      send_word(CMD_INSERT, 3, 32'sh5555_5555);
      send_word(CMD_INSERT, 2, 32'shAAAA_AAAA);
      send_word(CMD_INSERT, 63, 0);
      send_word(CMD_INSERT, 32, 0);
      send_word(CMD_DUMP, 0, 0);
      send_word(CMD_REMOVE, 0, 0);
      send_word(CMD_REMOVE, 3, 0);
      send_word(CMD_REMOVE, 3, 0);
      send_word(CMD_REMOVE, 63, 0);
      send_word(CMD_DUMP, 0, 0);
   endtask

   // Fill to capacity, then check that the range test wins over the full test.
   task automatic test_full_list();
      send_word(CMD_CLEAR, 0, 0);
      while (list_count < DEPTH) send_word(CMD_APPEND, 0, pick_value());
      send_word(CMD_APPEND, 0, 32'sd1);
      send_word(CMD_INSERT, 0, 32'sd2);
      send_word(CMD_INSERT, 32, 32'sd3);
      send_word(CMD_INSERT, 33, 32'sd4);
      send_word(CMD_DUMP, 0, 0);
      send_word(CMD_REMOVE, 31, 0);
      send_word(CMD_INSERT, 31, VAL_MAX);
      send_word(CMD_DUMP, 0, 0);
   endtask

   // The receiver stops for a long stretch while commands keep coming.
   task automatic test_backpressure();
      hold_left = 200;
      send_word(CMD_DUMP, 0, 0);
      random_items(30);
   endtask

   // Neither side idles for a while.
   task automatic test_full_rate();
      quiet = 1'b1;
      random_items(60);
      quiet = 1'b0;
   endtask

   // Receiver: random idle cycles, or a counted hold when one is requested.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // Compare each accepted result word with the oldest prediction.
   initial begin
      list_word_type got;
      list_word_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.status  = status_type'(rsp_tuser);
            got.element = rsp_tdata[31:0];
            got.count   = rsp_tdata[37:32];
            got.last    = rsp_tlast;
            if (pending_words.size() == 0) begin
               $error("unexpected result word: status %0d element %0d count %0d last %0b",
                      got.status, got.element, got.count, got.last);
               error_count++;
            end else begin
               want = pending_words.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  error_count++;
               end
               if (got.element !== want.element) begin
                  $error("element: expected %0d, got %0d", want.element, got.element);
                  error_count++;
               end
               if (got.count !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, got.count);
                  error_count++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, got.last);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // Reset, the test sequence, and the final verdict.
   initial begin
      reset       = 1'b1;
      req_tdata   = '0;
      req_tvalid  = 1'b0;
      rsp_tready  = 1'b0;
      list_count  = 0;
      error_count = 0;
      hold_left   = 0;
      quiet       = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_edges();
      test_full_list();
      random_items(150);
      test_backpressure();
      test_full_rate();
      random_items(180);

      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
